// File: rtl/rti_pkg.sv
// Shared types, constants and width helpers for the rank table.
package rti_pkg;

  localparam int OP_W          = 3;
  localparam int COUNT_W       = 7;
  localparam int RANK_W        = 7;
  localparam int SLOT_W        = 6;
  localparam int SIZE_W        = 7;
  localparam int MAX_NODES_DEF = 64;
  // cells whose match flags are folded together in the gather cycle
  localparam int GRP_SIZE      = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_ATTACH = 3'd1,
    OP_DETACH = 3'd2,
    OP_TAKE   = 3'd3,
    OP_FIND   = 3'd4
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] count;
    logic [RANK_W-1:0]  rank;
    logic [SLOT_W-1:0]  slot;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [RANK_W-1:0] rank_out;
    logic [SIZE_W-1:0] size_out;
  } out_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic               load;
    logic               apply;
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] count;
    logic [RANK_W-1:0]  rank;
    logic [SLOT_W-1:0]  slot;
  } cell_ctl_t;

  // width of a stored rank or of the live count
  function automatic int rank_w(input int n);
    int w;
    w = $clog2(n + 1);
    return (w > RANK_W) ? w : RANK_W;
  endfunction

  // width of a slot index, wide enough for the slot field as well
  function automatic int sel_w(input int n);
    int w;
    w = $clog2(n);
    return (w > SLOT_W) ? w : SLOT_W;
  endfunction

endpackage

// File: rtl/rti_cell.sv
// One slot of the rank table: holds a rank, adjusts it and takes its neighbour's on removal.
module rti_cell import rti_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int IDX       = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cell_ctl_t                      ctl,
  input  logic [rank_w(MAX_NODES)-1:0]   live,
  input  logic [$clog2(MAX_NODES)-1:0]   at,
  input  logic [rank_w(MAX_NODES)-1:0]   nbr,
  output logic [rank_w(MAX_NODES)-1:0]   tbl,
  output logic                           hit,
  output logic [rank_w(MAX_NODES)-1:0]   rd
);

  localparam int RW = rank_w(MAX_NODES);
  localparam int IW = $clog2(MAX_NODES);
  localparam int XW = sel_w(MAX_NODES);

  logic [RW-1:0] tbl_r;
  logic [RW-1:0] tbl_nxt;
  logic          hit_r;
  logic          sel_r;

  always_comb begin
    logic [RW-1:0] rk;
    logic [RW-1:0] myi;
    logic [RW-1:0] v;
    rk      = RW'(ctl.rank);
    myi     = RW'(IDX);
    v       = tbl_r;
    tbl_nxt = tbl_r;
    case (ctl.op)
      OP_INIT: begin
        tbl_nxt = (myi < RW'(ctl.count)) ? myi + RW'(1) : '0;
      end
      OP_ATTACH: begin
        // free slots hold zero, so only occupied ranks move up
        if (myi == live) begin
          tbl_nxt = rk;
        end else if (tbl_r >= rk) begin
          tbl_nxt = tbl_r + RW'(1);
        end
      end
      OP_DETACH: begin
        if (myi + RW'(1) == live) begin
          v = '0;
        end else if ((myi + RW'(1) < live) && (IW'(IDX) >= at)) begin
          v = nbr;
        end
        if (v > rk) begin
          v = v - RW'(1);
        end
        tbl_nxt = v;
      end
      default: begin
        tbl_nxt = tbl_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r <= '0;
    end else if (ctl.apply) begin
      tbl_r <= tbl_nxt;
    end
  end

  // match flags taken on the transfer cycle
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hit_r <= (tbl_r == RW'(ctl.rank));
      sel_r <= (XW'(ctl.slot) == XW'(IDX));
    end
  end

  assign tbl = tbl_r;
  assign hit = hit_r;
  assign rd  = sel_r ? tbl_r : '0;

endmodule

// File: rtl/rank_table_insert_delete.sv
// Rank table top level: control, gather stage and the row of slot cells.
//
// Input channel in_valid/in_ready/in_data carries one operation (init, attach,
// detach, take, find); output channel out_valid/out_ready/out_data returns one
// result per operation, in order.
// Each operation passes through the transfer cycle, where every cell compares
// its rank and slot index with the operands; a gather cycle, where the match
// flags are folded in groups of eight cells into registers; and an apply
// cycle, where the matched slot is formed, every cell adjusts or shifts its rank
// in parallel and the result is written to the output register. A new operation
// is taken only in the idle state, once the previous one has left its apply cycle.
// The output register lets a result wait while the next operation runs; if it
// is still held when that operation reaches its apply cycle, the block waits
// there with the table untouched until the receiver takes the result.
// Reset (rst_n low, synchronous) empties the table, clears every slot to zero
// and drops out_valid; the block takes operations in the cycle after.
module rank_table_insert_delete import rti_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int RW   = rank_w(MAX_NODES);
  localparam int IW   = $clog2(MAX_NODES);
  localparam int XW   = sel_w(MAX_NODES);
  localparam int NGRP = (MAX_NODES + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {S_IDLE, S_GATHER, S_APPLY} state_t;

  state_t        state_r;
  logic          out_valid_r;
  out_t          out_data_r;
  logic [RW-1:0] live_r;
  in_t           cmd_r;
  logic          okpre_r;

  logic          okpre;
  logic          finish;
  logic          ok;
  logic [RW-1:0] live_nxt;
  out_t          res;
  cell_ctl_t     ctl;

  logic [RW-1:0] tbl  [MAX_NODES];
  logic [RW-1:0] rd   [MAX_NODES];
  logic          hit  [MAX_NODES];

  logic [IW-1:0] at_grp_r  [NGRP];
  logic [RW-1:0] rd_grp_r  [NGRP];
  logic          fnd_grp_r [NGRP];
  logic [IW-1:0] at_grp    [NGRP];
  logic [RW-1:0] rd_grp    [NGRP];
  logic          fnd_grp   [NGRP];

  logic [IW-1:0] at_c;
  logic [RW-1:0] rd_c;
  logic          found_c;

  assign in_ready = (state_r == S_IDLE);
  assign finish   = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  // operand range checks against the current size
  always_comb begin
    logic [RW-1:0] rk;
    logic [RW-1:0] cnt;
    logic [RW-1:0] sl;
    rk  = RW'(in_data.rank);
    cnt = RW'(in_data.count);
    sl  = RW'(in_data.slot);
    case (in_data.op)
      OP_INIT:   okpre = (cnt <= RW'(MAX_NODES));
      OP_ATTACH: okpre = (live_r < RW'(MAX_NODES)) && (rk != '0) && (rk - RW'(1) <= live_r);
      OP_DETACH: okpre = (live_r != '0) && (rk != '0) && (rk <= live_r);
      OP_TAKE:   okpre = (sl < live_r);
      OP_FIND:   okpre = (rk != '0) && (rk <= live_r);
      default:   okpre = 1'b0;
    endcase
  end

  always_comb begin
    ctl.load  = in_valid && in_ready;
    ctl.apply = finish && ok;
    if (state_r == S_IDLE) begin
      ctl.op    = in_data.op;
      ctl.count = in_data.count;
      ctl.rank  = in_data.rank;
      ctl.slot  = in_data.slot;
    end else begin
      ctl.op    = cmd_r.op;
      ctl.count = cmd_r.count;
      ctl.rank  = cmd_r.rank;
      ctl.slot  = cmd_r.slot;
    end
  end

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    logic [RW-1:0] nbr;
    if (i == MAX_NODES - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = tbl[i+1];
    end
    rti_cell #(
      .MAX_NODES(MAX_NODES),
      .IDX      (i)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .live (live_r),
      .at   (at_c),
      .nbr  (nbr),
      .tbl  (tbl[i]),
      .hit  (hit[i]),
      .rd   (rd[i])
    );
  end

  // fold match flags group by group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      at_grp[g]  = '0;
      rd_grp[g]  = '0;
      fnd_grp[g] = 1'b0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < MAX_NODES) begin
          if (hit[g*GRP_SIZE+k]) begin
            at_grp[g] = at_grp[g] | IW'(g * GRP_SIZE + k);
          end
          fnd_grp[g] = fnd_grp[g] | hit[g*GRP_SIZE+k];
          rd_grp[g]  = rd_grp[g] | rd[g*GRP_SIZE+k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_GATHER) begin
      for (int g = 0; g < NGRP; g++) begin
        at_grp_r[g]  <= at_grp[g];
        rd_grp_r[g]  <= rd_grp[g];
        fnd_grp_r[g] <= fnd_grp[g];
      end
    end
  end

  // ranks are a permutation, so at most one occupied cell matches
  always_comb begin
    at_c    = '0;
    rd_c    = '0;
    found_c = 1'b0;
    for (int g = 0; g < NGRP; g++) begin
      at_c    = at_c | at_grp_r[g];
      rd_c    = rd_c | rd_grp_r[g];
      found_c = found_c | fnd_grp_r[g];
    end
  end

  always_comb begin
    logic [XW-1:0] at_x;
    at_x     = XW'(at_c);
    live_nxt = live_r;
    res      = '0;
    case (cmd_r.op)
      OP_DETACH, OP_FIND: ok = okpre_r && found_c;
      default:            ok = okpre_r;
    endcase
    if (ok) begin
      case (cmd_r.op)
        OP_INIT:   live_nxt = RW'(cmd_r.count);
        OP_ATTACH: live_nxt = live_r + RW'(1);
        OP_DETACH: live_nxt = live_r - RW'(1);
        default:   live_nxt = live_r;
      endcase
      case (cmd_r.op)
        OP_DETACH, OP_FIND: res.slot_out = at_x[SLOT_W-1:0];
        OP_TAKE:            res.rank_out = rd_c[RANK_W-1:0];
        default:            res.slot_out = '0;
      endcase
    end
    res.ok       = ok;
    res.size_out = live_nxt[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      cmd_r   <= in_data;
      okpre_r <= okpre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      live_r      <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_GATHER;
          end
        end
        S_GATHER: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (finish) begin
            out_data_r  <= res;
            live_r      <= live_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/rti_checker.sv
// Port-level checks on the rank table, bound to the top level.
module rti_checker import rti_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.slot_out == '0 && out_data.rank_out == '0)
    else $error("rejected operation carries a slot or rank");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.size_out) <= 32'(MAX_NODES) % 128)
    else $error("size beyond table depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an operation runs");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind rank_table_insert_delete rti_checker #(
  .MAX_NODES(MAX_NODES)
) u_rti_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
